// ===== rtl/ssp_pkg.sv =====
// Shared types, sine constants and coil patterns for the stepper speed profile block.
`timescale 1ns / 1ps

package ssp_pkg;

    // Odd-power coefficients of the quarter-wave sine polynomial, Q30
    localparam logic [63:0] SINE_C1  = 64'd1686629713;
    localparam logic [63:0] SINE_C3  = 64'd693598669;
    localparam logic [63:0] SINE_C5  = 64'd85569306;
    localparam logic [63:0] SINE_C7  = 64'd5026995;
    localparam logic [63:0] SINE_C9  = 64'd172272;
    localparam logic [63:0] SINE_C11 = 64'd3864;

    // Q16 magnitude ceiling (sine of one)
    localparam logic [16:0] MAG_ONE = 17'h10000;

    localparam int PEAK_W     = 8;
    localparam int TICK_CNT_W = 8;
    localparam int MAG_W      = 17;
    localparam int PROD_W     = PEAK_W + MAG_W;

    localparam logic [PEAK_W-1:0] PEAK_RESET = 8'd10;

    // Output queue geometry
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    // Accept a request only while two worst-case items still fit
    localparam logic [FIFO_AW:0] FIFO_ROOM_MAX = (FIFO_AW+1)'(FIFO_DEPTH - 4);

    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2,
        PHASE_3 = 2'd3
    } phase_t;

    localparam logic [3:0] COIL_PHASE_0 = 4'h9;
    localparam logic [3:0] COIL_PHASE_1 = 4'h5;
    localparam logic [3:0] COIL_PHASE_2 = 4'h6;
    localparam logic [3:0] COIL_PHASE_3 = 4'hA;

    typedef struct packed {
        logic       last_step;
        logic       direction_level;
        logic [3:0] coil_pattern;
    } result_t;

    // Results produced by one item: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [3:0] coil_of(input phase_t ph);
        logic [3:0] pat;
        case (ph)
            PHASE_0: pat = COIL_PHASE_0;
            PHASE_1: pat = COIL_PHASE_1;
            PHASE_2: pat = COIL_PHASE_2;
            PHASE_3: pat = COIL_PHASE_3;
            default: pat = COIL_PHASE_0;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/ssp_step.sv =====
// Step decision, sine profile table and motor state for the stepper speed profile block.
`timescale 1ns / 1ps

module ssp_step
    import ssp_pkg::*;
#(
    parameter int PROFILE_POINTS = 192
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              tick,
    input  logic [PEAK_W-1:0] peak_ticks,
    output push_t             push
);

    localparam int POS_W = $clog2(PROFILE_POINTS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PROFILE_POINTS - 1);
    localparam logic [POS_W-1:0] POS_INIT = POS_W'(PROFILE_POINTS / 6);

    // Table entry: {neg of next, zero of next, neg, magnitude}
    localparam int ENTRY_W = MAG_W + 3;

    // Fixed-point sine at one profile position: {neg, magnitude Q16}
    function automatic logic [MAG_W:0] sine_entry(input int pos);
        logic [63:0] f;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] acc;
        logic [63:0] s;
        logic        neg;
        f = 64'(pos) * 64'd4;
        q = f / PROFILE_POINTS;
        r = f % PROFILE_POINTS;
        if (q[0])
            r = 64'(PROFILE_POINTS) - r;
        z = (r << 30) / PROFILE_POINTS;
        z2 = (z * z) >> 30;
        acc = SINE_C11;
        acc = SINE_C9 - ((z2 * acc) >> 30);
        acc = SINE_C7 - ((z2 * acc) >> 30);
        acc = SINE_C5 - ((z2 * acc) >> 30);
        acc = SINE_C3 - ((z2 * acc) >> 30);
        acc = SINE_C1 - ((z2 * acc) >> 30);
        s = (z * acc) >> 30;
        s = (s + 64'd8192) >> 14;
        if (s > 64'(MAG_ONE))
            s = 64'(MAG_ONE);
        neg = (q >= 64'd2) && (z != 64'd0);
        return {neg, s[MAG_W-1:0]};
    endfunction

    logic [ENTRY_W-1:0] sine_tab [PROFILE_POINTS];

    for (genvar i = 0; i < PROFILE_POINTS; i++)
    begin : g_tab
        localparam logic [MAG_W:0] CUR = sine_entry(i);
        localparam logic [MAG_W:0] NXT = sine_entry((i + 1) % PROFILE_POINTS);
        assign sine_tab[i] = {NXT[MAG_W], (NXT[MAG_W-1:0] == '0), CUR};
    end

    logic [TICK_CNT_W-1:0] tick_count_reg, tick_count_next;
    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    logic [ENTRY_W-1:0]    entry;
    logic [MAG_W-1:0]      mag;
    logic                  neg_cur;
    logic                  zero_nxt;
    logic                  neg_nxt;
    logic [TICK_CNT_W-1:0] tc_upd;
    logic [PROD_W-1:0]     lhs;
    logic [PROD_W-1:0]     rhs;
    logic                  fire1;
    logic                  fire2;
    phase_t                phase1;
    phase_t                phase2;
    logic [POS_W-1:0]      pos1;
    logic [POS_W-1:0]      pos2;

    assign entry    = sine_tab[pos_reg];
    assign mag      = entry[MAG_W-1:0];
    assign neg_cur  = entry[MAG_W];
    assign zero_nxt = entry[MAG_W+1];
    assign neg_nxt  = entry[MAG_W+2];

    assign tc_upd = tick ? tick_count_reg + TICK_CNT_W'(1) : tick_count_reg;
    assign lhs    = {1'b0, tc_upd, 16'h0000};
    assign rhs    = PROD_W'(peak_ticks) * PROD_W'(mag);
    assign fire1  = (lhs >= rhs);
    // After a step the count is zero: another step is due only at zero threshold
    assign fire2  = fire1 && ((peak_ticks == '0) || zero_nxt);

    assign phase1 = neg_cur ? phase_t'(phase_reg - 2'd1) : phase_t'(phase_reg + 2'd1);
    assign phase2 = neg_nxt ? phase_t'(phase1 - 2'd1) : phase_t'(phase1 + 2'd1);
    assign pos1   = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
    assign pos2   = (pos1 == POS_LAST) ? '0 : pos1 + POS_W'(1);

    always_comb
    begin
        push.count                  = 2'd0;
        push.first.coil_pattern     = coil_of(phase_reg);
        push.first.direction_level  = neg_cur;
        push.first.last_step        = !fire2;
        push.second.coil_pattern    = coil_of(phase1);
        push.second.direction_level = neg_nxt;
        push.second.last_step       = 1'b1;
        tick_count_next             = tick_count_reg;
        phase_next                  = phase_reg;
        pos_next                    = pos_reg;
        if (item_valid)
        begin
            tick_count_next = fire1 ? '0 : tc_upd;
            if (fire2)
            begin
                push.count = 2'd2;
                phase_next = phase2;
                pos_next   = pos2;
            end
            else if (fire1)
            begin
                push.count = 2'd1;
                phase_next = phase1;
                pos_next   = pos1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            phase_reg      <= PHASE_0;
            pos_reg        <= POS_INIT;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

// ===== rtl/ssp_out_fifo.sv =====
// Result queue taking up to two steps per cycle and sending one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module ssp_out_fifo
    import ssp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t mem [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               pop;
    logic [FIFO_AW-1:0] wr_ptr_inc;

    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + FIFO_AW'(1);
    assign out_valid  = (cnt_reg != '0);
    assign out_data   = mem[rd_ptr_reg];
    assign room       = (cnt_reg <= FIFO_ROOM_MAX);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_inc] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/stepper_sine_speed_profile_core.sv =====
// Top level of the sine speed profile full-step sequencer for a four-coil stepper.
`timescale 1ns / 1ps

// Full-step sequencer for a four-coil stepper whose step rate follows a sine
// profile of PROFILE_POINTS positions. Each request on the slave stream is a
// timer tick (tdata bit 0 = 1) or a poll (0). Ticks are counted; once the count
// reaches peak_ticks * |sin(position)| the block sends one step on the master
// stream (coil pattern 9/5/6/A, direction bit, 1 = sine negative), clears the
// count, moves the phase forward or back and advances the position. At the two
// zero crossings of the sine a step follows at once, so one request can cause
// two steps; tlast marks the last step of a request, and a request causing no
// step sends nothing. Timing: a request is registered in the cycle it is
// accepted and its steps enter an eight-entry result queue in the next cycle;
// the first step can leave the queue the cycle after that. Requests are taken
// one per cycle while at most four steps sit in the queue; steps leave at one
// per cycle while m_axis_tready is high, so the output port sets the sustained
// rate when requests make two steps. peak_ticks (reset 10) is written on the
// cfg port, which is always ready; write it only while no request is in flight.

module stepper_sine_speed_profile_core
    import ssp_pkg::*;
#(
    parameter int PROFILE_POINTS = 192
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Slave stream: tdata bit 0 = tick, bits 7:1 zero
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    // Master stream: tdata bits 3:0 = coil_pattern, bit 4 = direction_level,
    // bits 7:5 zero
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast,
    // Configuration: peak_ticks
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PEAK_W-1:0] cfg_data
);

    logic [PEAK_W-1:0] peak_ticks_reg, peak_ticks_next;
    logic              item_valid_reg, item_valid_next;
    logic              tick_reg, tick_next;

    push_t   push;
    logic    room;
    result_t out_data;
    logic    in_accept;

    // Always take configuration writes
    assign cfg_ready     = 1'b1;
    // Hold off requests while the queue could not absorb two worst-case items
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        peak_ticks_next = (cfg_valid && cfg_ready) ? cfg_data : peak_ticks_reg;
        item_valid_next = in_accept;
        // Hold the payload when nothing is accepted; the valid flag gates it
        tick_next       = in_accept ? s_axis_tdata[0] : tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_ticks_reg <= PEAK_RESET;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            peak_ticks_reg <= peak_ticks_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
    end

    // Decide zero, one or two steps for the registered request and advance state
    ssp_step #(
        .PROFILE_POINTS (PROFILE_POINTS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .tick       (tick_reg),
        .peak_ticks (peak_ticks_reg),
        .push       (push)
    );

    // Queue the steps and hand them to the master stream one at a time
    ssp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {3'b000, out_data.direction_level, out_data.coil_pattern};
    assign m_axis_tlast = out_data.last_step;

endmodule

// ===== test/stepper_sine_speed_profile_core_test.sv =====
// Self-checking testbench for the stepper sine speed profile core.
`timescale 1ns / 1ps

module stepper_sine_speed_profile_core_test;
    import ssp_pkg::*;

    localparam int PROFILE_POINTS  = 192;
    localparam int RANDOM_REQUESTS = 1900;
    // Drop all idling on both streams for this many closing requests
    localparam int CALM_TAIL       = 250;
    // Idle cycles before a peak tick count write, so that a poll with no step has drained
    localparam int SETTLE_CYCLES   = 8;
    // Cycles to keep watching the output after the last expected step
    localparam int DRAIN_CYCLES    = 16;
    // Cycles with no handshake on any channel before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    // Odd-power coefficients of the quarter-wave sine, Q30
    localparam bit [63:0] Q30_C1  = 64'd1686629713;
    localparam bit [63:0] Q30_C3  = 64'd693598669;
    localparam bit [63:0] Q30_C5  = 64'd85569306;
    localparam bit [63:0] Q30_C7  = 64'd5026995;
    localparam bit [63:0] Q30_C9  = 64'd172272;
    localparam bit [63:0] Q30_C11 = 64'd3864;

    localparam logic [3:0] COIL_SEQ [4] = '{COIL_PHASE_0, COIL_PHASE_1,
                                            COIL_PHASE_2, COIL_PHASE_3};

    // Row kinds of the opening table
    localparam bit ROW_REQ = 1'b0;
    localparam bit ROW_CFG = 1'b1;
    localparam logic [7:0] TICK = 8'd1;
    localparam logic [7:0] POLL = 8'd0;

    // One row of the opening table. For a request, value[0] is the tick bit;
    // for a configuration row, value is the new peak tick count. Typed rows carry
    // their expected steps inline; all other rows go through the predictor.
    typedef struct packed {
        bit         kind;
        logic [7:0] value;
        bit         typed;
        logic [1:0] n_steps;
        logic [3:0] coil_a;
        logic       dir_a;
        logic [3:0] coil_b;
        logic       dir_b;
    } drive_row_t;

    localparam int NUM_OPENING = 22;

    // Reset state: peak tick count 10, position 32 (sine about 0.866), phase 0.
    // Eight ticks stay under 10 * 0.866, the ninth fires the first step.
    // With a peak tick count of 0 every request hits the two-step cap.
    localparam drive_row_t OPENING [NUM_OPENING] = '{
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd1, COIL_PHASE_0, 1'b0, 4'h0, 1'b0},
        // Poll right after a step: counter is zero, nothing fires
        '{ROW_REQ, POLL, 1'b1, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_CFG, 8'd0, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, POLL, 1'b1, 2'd2, COIL_PHASE_1, 1'b0, COIL_PHASE_2, 1'b0},
        '{ROW_REQ, TICK, 1'b1, 2'd2, COIL_PHASE_3, 1'b0, COIL_PHASE_0, 1'b0},
        '{ROW_CFG, 8'd255, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, POLL, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_CFG, 8'd1, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, POLL, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, POLL, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0},
        '{ROW_REQ, TICK, 1'b0, 2'd0, 4'h0, 1'b0, 4'h0, 1'b0}
    };

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data      = 8'd0;

    // Predictor state, mirrors the block after each accepted request
    logic [7:0]  prof_peak  = PEAK_RESET;
    logic [7:0]  prof_ticks = 8'd0;
    phase_t      prof_phase = PHASE_0;
    int unsigned prof_pos   = PROFILE_POINTS / 6;

    // Steps owed by the block, oldest first
    result_t pending_steps [$];

    // Idling controls, changed between phases of the random part
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit calm           = 1'b0;

    int errors       = 0;
    int n_requests   = 0;
    int n_steps      = 0;
    int n_backward   = 0;
    int n_zero_steps = 0;
    int n_cfg_writes = 0;

    stepper_sine_speed_profile_core #(
        .PROFILE_POINTS (PROFILE_POINTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // |sin(2*pi*pos/PROFILE_POINTS)| in Q16, rounded and capped at one.
    // Fold the position into a quarter wave, evaluate the odd polynomial
    // with floor shifts in Q30, then round to the nearest Q16 value.
    function automatic logic [16:0] sine_q16(input int unsigned pos, output bit neg);
        bit [63:0] f;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] z;
        bit [63:0] z2;
        bit [63:0] acc;
        bit [63:0] s;
        f = 64'(pos) * 64'd4;
        q = f / 64'(PROFILE_POINTS);
        r = f % 64'(PROFILE_POINTS);
        if (q[0])
            r = 64'(PROFILE_POINTS) - r;
        z   = (r << 30) / 64'(PROFILE_POINTS);
        z2  = (z * z) >> 30;
        acc = Q30_C11;
        acc = Q30_C9 - ((z2 * acc) >> 30);
        acc = Q30_C7 - ((z2 * acc) >> 30);
        acc = Q30_C5 - ((z2 * acc) >> 30);
        acc = Q30_C3 - ((z2 * acc) >> 30);
        acc = Q30_C1 - ((z2 * acc) >> 30);
        s   = (z * acc) >> 30;
        s   = (s + 64'd8192) >> 14;
        if (s > 64'd65536)
            s = 64'd65536;
        // Sine is negative in the second half, except exactly at the zero point
        neg = (q >= 64'd2) && (z != 64'd0);
        return s[16:0];
    endfunction

    // Apply one request to the predictor; return how many steps it fires
    // (at most two) and the steps themselves.
    function automatic int advance_profile(input logic tick, output result_t first_step,
                                           output result_t second_step);
        result_t     made [2];
        bit          neg;
        logic [16:0] mag;
        int          n;
        n       = 0;
        made[0] = '0;
        made[1] = '0;
        if (tick)
            prof_ticks = prof_ticks + 8'd1;
        while (n < 2)
        begin
            mag = sine_q16(prof_pos, neg);
            // Hold while the counter is below peak_ticks * |sin|
            if ((64'(prof_ticks) << 16) < (64'(prof_peak) * 64'(mag)))
                break;
            made[n].coil_pattern    = COIL_SEQ[prof_phase];
            made[n].direction_level = neg;
            made[n].last_step       = 1'b0;
            if (mag == 17'd0)
                n_zero_steps++;
            prof_ticks = 8'd0;
            prof_phase = neg ? phase_t'(prof_phase - 2'd1) : phase_t'(prof_phase + 2'd1);
            prof_pos   = (prof_pos + 1 >= PROFILE_POINTS) ? 0 : prof_pos + 1;
            n++;
        end
        if (n > 0)
            made[n-1].last_step = 1'b1;
        first_step  = made[0];
        second_step = made[1];
        return n;
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // Present one request, wait for the handshake, then queue the steps it owes.
    // tvalid stays high on return; the caller's next action replaces or drops it
    // in the same time step.
    task automatic issue_request(input drive_row_t row);
        result_t first_step;
        result_t second_step;
        int      n;
        if (!calm && sender_idles && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, row.value[0]};
        do @(posedge clk); while (!s_axis_tready);
        n = advance_profile(row.value[0], first_step, second_step);
        if (row.typed)
        begin
            n = int'(row.n_steps);
            first_step.coil_pattern     = row.coil_a;
            first_step.direction_level  = row.dir_a;
            first_step.last_step        = (n == 1);
            second_step.coil_pattern    = row.coil_b;
            second_step.direction_level = row.dir_b;
            second_step.last_step       = 1'b1;
        end
        if (n > 0)
            pending_steps.push_back(first_step);
        if (n > 1)
            pending_steps.push_back(second_step);
        n_requests++;
    endtask

    // Write the peak tick count only once the block is idle: drop the request
    // stream, wait out every owed step plus a settle window for trailing polls.
    task automatic write_peak_ticks(input logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        prof_peak = value;
        n_cfg_writes++;
    endtask

    // Output side: stall in random bursts while receiver idling is on, unless told to stay calm
    initial
    begin : drain_steps
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && receiver_idles && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare every accepted step with the oldest one owed
    always @(posedge clk)
    begin : check_steps
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_steps.size() == 0)
                flag_mismatch($sformatf("step tdata=%h tlast=%b with none owed",
                                        m_axis_tdata, m_axis_tlast));
            else
            begin
                want = pending_steps.pop_front();
                n_steps++;
                if (want.direction_level)
                    n_backward++;
                if (m_axis_tdata[3:0] !== want.coil_pattern)
                    flag_mismatch($sformatf("coil_pattern exp %h got %h",
                                            want.coil_pattern, m_axis_tdata[3:0]));
                if (m_axis_tdata[4] !== want.direction_level)
                    flag_mismatch($sformatf("direction_level exp %b got %b",
                                            want.direction_level, m_axis_tdata[4]));
                if (m_axis_tlast !== want.last_step)
                    flag_mismatch($sformatf("last_step exp %b got %b",
                                            want.last_step, m_axis_tlast));
            end
        end
    end

    // Hang detector: any handshake on any channel resets the count
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d steps still owed",
                         quiet, pending_steps.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        drive_row_t row;
        int         n_random;
        int         phase_len;
        int         tick_pct;
        int         pick;
        logic [7:0] peak_pick;
        n_random = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening table: reset behavior, both peak tick count extremes, step cap
        for (int i = 0; i < NUM_OPENING; i++)
        begin
            if (OPENING[i].kind == ROW_CFG)
                write_peak_ticks(OPENING[i].value);
            else
                issue_request(OPENING[i]);
        end

        // Random phases: each picks a peak tick count, a tick density and idling mix.
        // Small values dominate so the position sweeps the whole profile many
        // times, through both zero points and the negative half. The closing
        // phase runs all remaining requests with no idling on either side.
        while (n_random < RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                peak_pick = 8'd0;
            else if (pick == 1)
                peak_pick = 8'd255;
            else if (pick <= 6)
                peak_pick = 8'($urandom_range(1, 16));
            else
                peak_pick = 8'($urandom_range(0, 255));
            write_peak_ticks(peak_pick);
            phase_len      = $urandom_range(40, 160);
            tick_pct       = $urandom_range(30, 100);
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            calm           = (n_random >= RANDOM_REQUESTS - CALM_TAIL);
            if (calm)
                phase_len = RANDOM_REQUESTS - n_random;
            for (int k = 0; k < phase_len && n_random < RANDOM_REQUESTS; k++)
            begin
                row       = '0;
                row.kind  = ROW_REQ;
                row.value = ($urandom_range(1, 100) <= tick_pct) ? TICK : POLL;
                issue_request(row);
                n_random++;
            end
        end

        // Drop the request stream, collect everything owed, then watch a while
        // longer for stray steps
        s_axis_tvalid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests and %0d peak tick count writes; checked %0d steps,",
                 n_requests, n_cfg_writes, n_steps);
        $display("%0d of them anticlockwise and %0d fired at a sine zero point.",
                 n_backward, n_zero_steps);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
